### rtl/gts_pkg.sv
// Shared types and constants of the glyph text search block.
package gts_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_NEEDLE = 2'd1;
  localparam logic [1:0] OP_GLYPH  = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] CFG_CASE    = 2'd0;
  localparam logic [1:0] CFG_MAXM    = 2'd1;
  localparam logic [1:0] CFG_ASCENT  = 2'd2;
  localparam logic [1:0] CFG_DESCENT = 2'd3;

  localparam int CP_W    = 21;
  localparam int COORD_W = 32;
  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One word handed from the front to the back.
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         nbyte;
    logic [CP_W-1:0]    cp;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] adv;
    logic [COORD_W-1:0] hgt;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        start_idx;
    logic [15:0]        end_idx;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COUNT_W-1:0] count;
    logic               status;
  } result_t;

  function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] cp,
                                              input logic cs);
    if (!cs && cp >= CP_W'(8'h41) && cp <= CP_W'(8'h5A)) begin
      return cp + CP_W'(32);
    end
    return cp;
  endfunction

  // The input is wide enough for a baseline less a full-scale scaled height.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W+2:0] v);
    if (v > (COORD_W+3)'(signed'(32'sh7FFFFFFF))) return 32'sh7FFFFFFF;
    if (v < -(COORD_W+3)'(64'sd2147483648)) return 32'sh80000000;
    return v[COORD_W-1:0];
  endfunction

endpackage

### rtl/gts_front.sv
// Front end: input word queue of two entries between the input port and the back end.
module gts_front import gts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);
  item_t     mem_q [2];
  logic      wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

### rtl/gts_back.sv
// Back end: needle decoding, glyph window, comparison and box gathering.
module gts_back import gts_pkg::*; #(
  parameter int NeedleMax = 256,
  parameter int GlyphCap  = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  item_t              q_item_i,
  input  logic               case_sensitive_i,
  input  logic [COUNT_W-1:0] max_matches_i,
  input  logic [15:0]        ascent_i,
  input  logic [15:0]        descent_i,
  output logic               r_valid_o,
  input  logic               r_ready_i,
  output result_t            r_o
);
  localparam int AW  = (NeedleMax > 1) ? $clog2(NeedleMax) : 1;
  localparam int LW  = $clog2(NeedleMax + 1);
  localparam int GW0 = $clog2(GlyphCap + 1);
  localparam int GW  = (GW0 > LW) ? GW0 : LW;
  // The window is a power of two deep so that glyph indices wrap by truncation;
  // only the last needle-length entries are ever read.
  localparam int WinDepth = 2 ** AW;

  localparam logic [2:0] S_IDLE = 3'd0, S_CMP = 3'd1, S_CMPW = 3'd2,
                         S_BOX = 3'd3, S_BOXW = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;

  logic [2:0] st_q, st_d;
  logic [CP_W-1:0] needle_mem [NeedleMax];
  logic [CP_W-1:0] wcode_mem [WinDepth];
  logic [4*COORD_W-1:0] wgeo_mem [WinDepth];

  logic [LW-1:0] nlen_q;
  logic [CP_W-1:0] part_q;
  logic [1:0] exp_q;
  logic [GW-1:0] gcnt_q;
  logic [COUNT_W-1:0] found_q;
  logic [LW-1:0] k_q;
  logic [GW-1:0] first_q, g_q;
  logic [AW-1:0] ra_n, ra_w;
  logic [CP_W-1:0] nrd_q, wrd_q;
  logic [4*COORD_W-1:0] grd_q;
  logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, gy_q;
  logic signed [63:0] pa_q, pd_q;
  logic first_box_q;
  logic r_valid_q;
  result_t r_q;

  assign r_valid_o = r_valid_q;
  assign r_o = r_q;
  assign q_ready_o = (st_q == S_IDLE) && !r_valid_q;

  logic take;
  assign take = q_valid_i && q_ready_o;

  // Needle byte decoding.
  logic [7:0] b;
  logic keep;
  logic [CP_W-1:0] keep_cp, part_d;
  logic [1:0] exp_d;
  assign b = q_item_i.nbyte;
  always_comb begin
    keep = 1'b0; keep_cp = '0; part_d = part_q; exp_d = exp_q;
    if (b == 8'h00) begin
      part_d = '0; exp_d = 2'd0;
    end else if (exp_q != 2'd0 && (b & 8'hC0) == 8'h80) begin
      part_d = {part_q[CP_W-7:0], b[5:0]};
      exp_d  = exp_q - 2'd1;
      if (exp_q == 2'd1) begin
        keep = 1'b1; keep_cp = {part_q[CP_W-7:0], b[5:0]};
      end
    end else begin
      exp_d = 2'd0; part_d = '0;
      if ((b & 8'h80) == 8'h00) begin
        keep = 1'b1; keep_cp = CP_W'(b);
      end else if ((b & 8'hE0) == 8'hC0) begin
        part_d = CP_W'(b & 8'h1F); exp_d = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
        part_d = CP_W'(b & 8'h0F); exp_d = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
        part_d = CP_W'(b & 8'h07); exp_d = 2'd3;
      end
    end
  end

  logic needle_wr, glyph_wr;
  assign needle_wr = take && q_item_i.op == OP_NEEDLE && nlen_q < LW'(NeedleMax)
                     && gcnt_q == '0;
  assign glyph_wr = take && q_item_i.op == OP_GLYPH && gcnt_q < GW'(GlyphCap);

  logic [GW-1:0] gp1;
  assign gp1 = gcnt_q + GW'(1);

  // Window address of entry k of the current candidate.
  assign ra_w = AW'(first_q + GW'(k_q));
  assign ra_n = AW'(k_q);

  always_ff @(posedge clk_i) begin
    if (needle_wr && keep) needle_mem[AW'(nlen_q)] <= keep_cp;
    if (glyph_wr) begin
      wcode_mem[AW'(gcnt_q)] <= q_item_i.cp;
      wgeo_mem[AW'(gcnt_q)]  <= {q_item_i.x, q_item_i.y, q_item_i.adv, q_item_i.hgt};
    end
    nrd_q <= needle_mem[ra_n];
    wrd_q <= wcode_mem[ra_w];
    grd_q <= wgeo_mem[ra_w];
  end

  logic signed [COORD_W-1:0] gx, gy, ga, gh;
  assign {gx, gy, ga, gh} = grd_q;

  logic signed [63:0] qa, qd;
  logic signed [COORD_W-1:0] tr, tt, tb;
  always_comb begin
    // Truncation toward zero of the Q.14 products.
    qa = (pa_q < 0) ? -((-pa_q) >>> 14) : (pa_q >>> 14);
    qd = (pd_q < 0) ? -((-pd_q) >>> 14) : (pd_q >>> 14);
    tt = sat32($signed({{3{gy_q[COORD_W-1]}}, gy_q}) - $signed(qa[COORD_W+2:0]));
    tb = sat32($signed({{3{gy_q[COORD_W-1]}}, gy_q}) + $signed(qd[COORD_W+2:0]));
    tr = sat32($signed({{3{gx[COORD_W-1]}}, gx}) + $signed({{3{ga[COORD_W-1]}}, ga}));
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (glyph_wr && nlen_q != '0 && gp1 >= GW'(nlen_q)) st_d = S_CMPW;
      S_CMPW: st_d = S_CMP;
      S_CMP: begin
        if (fold_cp(wrd_q, case_sensitive_i) != fold_cp(nrd_q, case_sensitive_i))
          st_d = S_IDLE;
        else if (k_q == nlen_q - LW'(1)) st_d = S_BOXW;
        else st_d = S_CMPW;
      end
      S_BOXW: st_d = S_BOX;
      S_BOX: st_d = S_MUL;
      S_MUL: st_d = (k_q == nlen_q - LW'(1)) ? S_OUT : S_BOXW;
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; nlen_q <= '0; part_q <= '0; exp_q <= '0;
      gcnt_q <= '0; found_q <= '0; k_q <= '0; r_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (r_valid_q && r_ready_i) r_valid_q <= 1'b0;
      if (take) begin
        unique case (q_item_i.op)
          OP_START: begin
            nlen_q <= '0; part_q <= '0; exp_q <= '0; gcnt_q <= '0; found_q <= '0;
          end
          OP_NEEDLE: if (needle_wr) begin
            part_q <= part_d; exp_q <= exp_d;
            if (keep) nlen_q <= nlen_q + LW'(1);
          end
          OP_GLYPH: if (glyph_wr) begin
            gcnt_q <= gp1; k_q <= '0;
          end
          OP_FINISH: r_valid_q <= 1'b1;
          default: ;
        endcase
      end
      if (st_q == S_CMP && st_d == S_CMPW) k_q <= k_q + LW'(1);
      if (st_q == S_CMP && st_d == S_BOXW) k_q <= '0;
      if (st_q == S_MUL && st_d == S_BOXW) k_q <= k_q + LW'(1);
      if (st_q == S_OUT) begin
        if (found_q < max_matches_i) r_valid_q <= 1'b1;
        if (found_q != COUNT_MAX) found_q <= found_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      g_q <= gcnt_q;
      first_q <= gp1 - GW'(nlen_q);
      first_box_q <= 1'b1;
      if (q_item_i.op == OP_FINISH) begin
        r_q <= '{kind: 1'b1, start_idx: '0, end_idx: '0, left: '0, top: '0,
                 right: '0, bottom: '0, count: found_q, status: (nlen_q == '0)};
      end
    end
    if (st_q == S_BOX) begin
      pa_q <= $signed(gh) * $signed({1'b0, ascent_i});
      pd_q <= $signed(gh) * $signed({1'b0, descent_i});
      gy_q <= gy;
      if (first_box_q) begin
        x0_q <= gx; x1_q <= (tr > gx) ? tr : gx; y0_q <= gy; y1_q <= gy;
      end else begin
        if (gx < x0_q) x0_q <= gx;
        if (tr > x1_q) x1_q <= tr;
      end
    end
    if (st_q == S_MUL) begin
      first_box_q <= 1'b0;
      if (tt < y0_q) y0_q <= tt;
      if (tb > y1_q) y1_q <= tb;
    end
    if (st_q == S_OUT) begin
      r_q <= '{kind: 1'b0, start_idx: 16'(first_q), end_idx: 16'(g_q), left: x0_q,
               top: y0_q, right: x1_q, bottom: y1_q, count: '0, status: 1'b0};
    end
  end
endmodule

### rtl/glyph_text_search_top.sv
// Top level of the glyph text search block.
// Input channel in_valid_i/in_ready_o carries one word: an operation (start,
// needle byte, glyph, finish) with its fields. Output channel out_valid_o/
// out_ready_i carries a match record or a finish summary.
// A two-entry queue decouples the input port from the back end, which holds
// the needle and a window of the last glyphs in memories. A word is stored
// in the queue before the back end can take it. Start, needle words and
// non-matching glyph prefixes leave the back end idle; a glyph that could
// end a match is compared per needle code point in a read-wait and a compare
// state, as the window memory has one registered read port, and a full match
// then gathers its box per code point in a read-wait, a box and a multiply
// state, then an output state. A finish raises its summary in the cycle after
// it is taken. Reset empties the needle and resets the counters, state and
// settings to defaults. While the receiver stalls a result, the back end takes
// no further word; the queue keeps taking up to two words.
module glyph_text_search_top import gts_pkg::*; #(
  parameter int NeedleMax = 256,
  parameter int GlyphCap  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  needle_byte_i,
  input  logic [20:0] code_point_i,
  input  logic signed [31:0] glyph_x_i,
  input  logic signed [31:0] glyph_y_i,
  input  logic signed [31:0] glyph_advance_i,
  input  logic signed [31:0] glyph_height_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] start_index_o,
  output logic [15:0] end_index_o,
  output logic signed [31:0] box_left_o,
  output logic signed [31:0] box_top_o,
  output logic signed [31:0] box_right_o,
  output logic signed [31:0] box_bottom_o,
  output logic [16:0] match_count_o,
  output logic        status_o
);
  logic cs_q;
  logic [COUNT_W-1:0] maxm_q;
  logic [15:0] asc_q, desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= 1'b0; maxm_q <= 17'd65536; asc_q <= 16'd12288; desc_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CASE:    cs_q   <= cfg_data_i[0];
        CFG_MAXM:    maxm_q <= cfg_data_i;
        CFG_ASCENT:  asc_q  <= cfg_data_i[15:0];
        CFG_DESCENT: desc_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  item_t in_item, q_item;
  logic q_valid, q_ready;
  result_t res;

  assign in_item = '{op: operation_i, nbyte: needle_byte_i, cp: code_point_i,
                     x: glyph_x_i, y: glyph_y_i, adv: glyph_advance_i,
                     hgt: glyph_height_i};

  gts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  gts_back #(.NeedleMax(NeedleMax), .GlyphCap(GlyphCap)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .case_sensitive_i(cs_q), .max_matches_i(maxm_q), .ascent_i(asc_q),
    .descent_i(desc_q), .r_valid_o(out_valid_o), .r_ready_i(out_ready_i), .r_o(res)
  );

  assign result_kind_o = res.kind;
  assign start_index_o = res.start_idx;
  assign end_index_o   = res.end_idx;
  assign box_left_o    = res.left;
  assign box_top_o     = res.top;
  assign box_right_o   = res.right;
  assign box_bottom_o  = res.bottom;
  assign match_count_o = res.count;
  assign status_o      = res.status;

  // A summary never carries a box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> start_index_o == '0 && box_left_o == '0)
    else $error("summary with box fields");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_count_o))
    else $error("stalled result changed");

  // The box of a match record never has its left edge past its right edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> box_left_o <= box_right_o)
    else $error("box left past right");
endmodule
